// ===== sv/hlb_pkg.sv =====
package hlb_pkg;

  localparam int unsigned MAX_STATES = 16384;
  localparam int unsigned MAX_SITES  = 16;
  localparam int unsigned MAX_LINKS  = 16;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned SITE_W = 5;
  localparam int unsigned IDX_W  = $clog2(MAX_STATES);
  localparam int unsigned NXT_W  = IDX_W + 1;
  localparam int unsigned CNT_W  = $clog2(MAX_LINKS);

  localparam logic [SITE_W-1:0] SITES_RESET = SITE_W'(MAX_SITES);
  localparam logic [SITE_W-1:0] SITES_MIN   = SITE_W'(2);
  localparam logic [SITE_W-1:0] SITES_MAX   = SITE_W'(MAX_SITES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } hlb_state_e;

  typedef struct packed {
    logic [IDX_W-1:0] new_index;
    logic [IDX_W-1:0] old_index;
    logic             negative_sign;
    logic             link_found;
    logic             store_full;
    logic             last_result;
  } hlb_result_t;

endpackage

// ===== sv/hopping_link_builder.sv =====
// Scan: an item stored at index n is compared with the earlier words, newest first, one
// earlier word per cycle (bounded by the single read port of the word memory) unless a
// held link cannot leave; earlier links leave as the scan finds the next one.
// A new item is taken only once the last result of the previous one has been issued;
// a rejected item (store full) gives one flagged result. Output stalls hold the block.
// Reset: next index 1, site count 16, output empty; the word memory is not cleared
// since only entries written since reset are ever used.
module hopping_link_builder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: site count
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hlb_pkg::SITE_W-1:0]    cfg_site_count_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hlb_pkg::WORD_W-1:0]    occupancy_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hlb_pkg::IDX_W-1:0]     new_index_o,
  output logic [hlb_pkg::IDX_W-1:0]     old_index_o,
  output logic                          negative_sign_o,
  output logic                          link_found_o,
  output logic                          store_full_o,
  output logic                          last_result_o
);
  import hlb_pkg::*;

  // Word memory: one write port (new item), one registered read port (scan).
  logic [WORD_W-1:0] word_mem_q [MAX_STATES];
  logic [WORD_W-1:0] rd_data_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;

  hlb_state_e        state_q, state_d;
  logic [SITE_W-1:0] sites_q, sites_d;
  logic [NXT_W-1:0]  next_index_q, next_index_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [WORD_W-1:0] mask_q, mask_d;
  logic [WORD_W-1:0] half_q, half_d;
  logic [WORD_W-1:0] wrap_q, wrap_d;
  logic [CNT_W-1:0]  count_q, count_d;
  // Newest link found so far; held back one step so the final one can be marked.
  logic              pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;
  logic              pend_neg_q, pend_neg_d;
  // Output register
  logic              out_vld_q, out_vld_d;
  hlb_result_t       out_q, out_d;

  logic              out_free;
  logic              in_acc;
  logic              store_is_full;
  logic [SITE_W-1:0] sites_eff;
  logic [WORD_W-1:0] old_word;
  logic [WORD_W-1:0] abs_diff;
  logic              is_pos, is_neg, hit, adv;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_vld_q || !out_stall_i;
  assign in_stall_o    = (state_q != S_IDLE) || !out_free;
  assign in_acc        = in_valid_i && !in_stall_o;
  assign store_is_full = (next_index_q == NXT_W'(MAX_STATES));

  // Clamp the site count into the legal range.
  always_comb begin
    sites_eff = sites_q;
    if (sites_q < SITES_MIN) sites_eff = SITES_MIN;
    if (sites_q > SITES_MAX) sites_eff = SITES_MAX;
  end

  // Compare the stored word against the word being placed.
  assign old_word = rd_data_q & mask_q;
  assign abs_diff = (word_q >= old_word) ? (word_q - old_word) : (old_word - word_q);
  assign is_pos   = (abs_diff != '0) && ((abs_diff & (abs_diff - WORD_W'(1))) == '0) &&
                    (abs_diff < half_q);
  assign is_neg   = (abs_diff == wrap_q);
  assign hit      = is_pos || is_neg;
  // Hold the scan when a second link arrives but the pending one cannot leave.
  assign adv      = !(hit && pend_vld_q && !out_free);

  always_comb begin
    state_d      = state_q;
    sites_d      = sites_q;
    next_index_d = next_index_q;
    cur_d        = cur_q;
    cmp_idx_d    = cmp_idx_q;
    word_d       = word_q;
    mask_d       = mask_q;
    half_d       = half_q;
    wrap_d       = wrap_q;
    count_d      = count_q;
    pend_vld_d   = pend_vld_q;
    pend_idx_d   = pend_idx_q;
    pend_neg_d   = pend_neg_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q && out_stall_i;
    mem_we       = 1'b0;
    rd_addr      = cmp_idx_q;

    if (cfg_valid_i && cfg_ready_o) sites_d = cfg_site_count_i;

    case (state_q)
      S_IDLE: begin
        rd_addr = next_index_q[IDX_W-1:0] - IDX_W'(1);
        if (in_acc) begin
          if (store_is_full) begin
            // Reject: one flagged result, nothing stored.
            out_d           = '0;
            out_d.store_full  = 1'b1;
            out_d.last_result = 1'b1;
            out_vld_d       = 1'b1;
          end else begin
            mask_d       = WORD_W'((17'(1) << sites_eff) - 17'(1));
            half_d       = WORD_W'(17'(1) << (sites_eff - SITE_W'(1)));
            wrap_d       = WORD_W'((17'(1) << (sites_eff - SITE_W'(1))) - 17'(1));
            word_d       = occupancy_i & WORD_W'((17'(1) << sites_eff) - 17'(1));
            mem_we       = 1'b1;
            cur_d        = next_index_q[IDX_W-1:0];
            next_index_d = next_index_q + NXT_W'(1);
            cmp_idx_d    = next_index_q[IDX_W-1:0] - IDX_W'(1);
            count_d      = '0;
            pend_vld_d   = 1'b0;
            // The first word has nothing to compare against.
            state_d      = (next_index_q == NXT_W'(1)) ? S_FLUSH : S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (adv) begin
          if (hit) begin
            pend_vld_d = 1'b1;
            pend_idx_d = cmp_idx_q;
            pend_neg_d = is_neg;
            count_d    = count_q + CNT_W'(1);
            if (pend_vld_q) begin
              out_d.new_index     = cur_q;
              out_d.old_index     = pend_idx_q;
              out_d.negative_sign = pend_neg_q;
              out_d.link_found    = 1'b1;
              out_d.store_full    = 1'b0;
              out_d.last_result   = 1'b0;
              out_vld_d           = 1'b1;
            end
          end
          // Stop at the oldest word or once the link limit is reached.
          if ((cmp_idx_q == IDX_W'(1)) ||
              (hit && (count_q == CNT_W'(MAX_LINKS - 1)))) begin
            state_d = S_FLUSH;
          end else begin
            cmp_idx_d = cmp_idx_q - IDX_W'(1);
            rd_addr   = cmp_idx_q - IDX_W'(1);
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_d.new_index     = cur_q;
          out_d.old_index     = pend_vld_q ? pend_idx_q : '0;
          out_d.negative_sign = pend_vld_q && pend_neg_q;
          out_d.link_found    = pend_vld_q;
          out_d.store_full    = 1'b0;
          out_d.last_result   = 1'b1;
          out_vld_d           = 1'b1;
          pend_vld_d          = 1'b0;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sites_q      <= SITES_RESET;
      next_index_q <= NXT_W'(1);
      pend_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      sites_q      <= sites_d;
      next_index_q <= next_index_d;
      pend_vld_q   <= pend_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    cmp_idx_q  <= cmp_idx_d;
    word_q     <= word_d;
    mask_q     <= mask_d;
    half_q     <= half_d;
    wrap_q     <= wrap_d;
    count_q    <= count_d;
    pend_idx_q <= pend_idx_d;
    pend_neg_q <= pend_neg_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) word_mem_q[next_index_q[IDX_W-1:0]] <= word_d;
    rd_data_q <= word_mem_q[rd_addr];
  end

  assign out_valid_o     = out_vld_q;
  assign new_index_o     = out_q.new_index;
  assign old_index_o     = out_q.old_index;
  assign negative_sign_o = out_q.negative_sign;
  assign link_found_o    = out_q.link_found;
  assign store_full_o    = out_q.store_full;
  assign last_result_o   = out_q.last_result;

  // A rejected item gives exactly one bare, final result.
  a_full_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_full_o |-> last_result_o && !link_found_o && new_index_o == '0)
    else $error("store-full result malformed");

  // A link always points to an older, valid index.
  a_link_older: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && link_found_o |-> old_index_o != '0 && old_index_o < new_index_o)
    else $error("link to invalid index");

  // The scan only visits words stored before the current one.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> cmp_idx_q < cur_q && cmp_idx_q != '0)
    else $error("scan index out of range");

  // No link is left pending once the block is idle.
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_vld_q)
    else $error("pending link while idle");

endmodule
